>>> sv/imubsc_pkg.sv
// Shared constants and types for the IMU bias and scale compensation block.
package imubsc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int AXIS_COUNT_DEF   = 3;
    localparam int AXIS_MAX         = 3;
    localparam int SCALE_W          = 32;
    localparam int IVL_W            = 16;
    localparam int Q_FRAC           = 30;
    localparam int DEN_W            = SCALE_W;

    localparam logic OP_CORR    = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;
    localparam logic SENS_GYRO  = 1'b0;
    localparam logic SENS_ACCEL = 1'b1;

    localparam logic [SCALE_W+1:0] DIV_ONE = (SCALE_W + 2)'(1) << Q_FRAC;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } t_div_stat;

endpackage

>>> sv/imubsc_sdiv.sv
// Bit-serial restoring divider: (mag << 30) / den, one quotient bit per cycle.
module imubsc_sdiv #(
    parameter int SAMPLE_WIDTH = imubsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  imubsc_pkg::t_div_ctl            i_ctl,
    input  logic [SAMPLE_WIDTH-1:0]         i_mag,
    input  logic [imubsc_pkg::DEN_W-1:0]    i_den,
    output imubsc_pkg::t_div_stat           o_stat,
    output logic [SAMPLE_WIDTH-2:0]         o_quo
);
    import imubsc_pkg::*;

    localparam int NUM_W = SAMPLE_WIDTH + Q_FRAC;
    localparam int QW    = SAMPLE_WIDTH - 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [QW-1:0]      r_num;
    logic [QW-1:0]      r_quo;

    logic [NUM_W-1:0]   w_num;
    logic [DEN_W-1:0]   w_head;
    logic               w_head_ovf;
    logic [DEN_W:0]     w_trial;
    logic [DEN_W:0]     w_sub;
    logic               w_ge;

    assign w_num      = {i_mag, {Q_FRAC{1'b0}}};
    assign w_head     = DEN_W'(w_num[NUM_W-1:QW]);
    // quotient would reach 2^(SAMPLE_WIDTH-1): saturate without iterating
    assign w_head_ovf = w_head >= i_den;
    assign w_trial    = {r_rem, r_num[QW-1]};
    assign w_sub      = w_trial - {1'b0, r_den};
    assign w_ge       = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_ctl.start) begin
                r_done <= w_head_ovf;
                if (w_head_ovf) begin
                    r_sat  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_sat  <= 1'b0;
                    r_cnt  <= CNT_W'(QW);
                end
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= r_cnt == CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= w_head;
            r_num <= w_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
            r_num <= {r_num[QW-2:0], 1'b0};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done, sat: r_sat};
    assign o_quo  = r_quo;

endmodule

>>> sv/imu_bias_scale_compensation.sv
// IMU bias and scale-factor compensation: correction store and serial divide path.
//
//  channel | handshake                  | beat
//  --------+----------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_ready    | op, axis, sensor, rates, interval, sample
//  out     | o_out_valid / i_out_ready  | six compensated axes and scale_fault
//
//  Correction beat: bit-serial multiply of bias_rate by interval, then rounding and write-back.
//  Sample beat: one bit-serial divider serves each gyro axis, then each accel axis, in turn;
//  an axis whose divisor is not positive skips the divide and sets scale_fault.
//  Reset: all bias and scale entries cleared to zero.
//  A result waits in the output register; the next beat is taken meanwhile, and a
//  following sample holds its result until that register is free.
module imu_bias_scale_compensation #(
    parameter int SAMPLE_WIDTH = imubsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int AXIS_COUNT   = imubsc_pkg::AXIS_COUNT_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_op,
    input  logic [1:0]                              i_axis,
    input  logic                                    i_sensor,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_bias_rate,
    input  logic signed [imubsc_pkg::SCALE_W-1:0]   i_scale_delta,
    input  logic [imubsc_pkg::IVL_W-1:0]            i_interval,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_gyro_x,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_gyro_y,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_gyro_z,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_accel_z,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]          o_comp_gyro_x,
    output logic signed [SAMPLE_WIDTH-1:0]          o_comp_gyro_y,
    output logic signed [SAMPLE_WIDTH-1:0]          o_comp_gyro_z,
    output logic signed [SAMPLE_WIDTH-1:0]          o_comp_accel_x,
    output logic signed [SAMPLE_WIDTH-1:0]          o_comp_accel_y,
    output logic signed [SAMPLE_WIDTH-1:0]          o_comp_accel_z,
    output logic                                    o_scale_fault
);
    import imubsc_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int ACC_W = SW + IVL_W;
    localparam int MCW   = $clog2(IVL_W);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_RND   = 9'b000000100,
        S_CWB   = 9'b000001000,
        S_SETUP = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_WAIT  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

    t_state                     r_state;
    logic signed [SW-1:0]       r_gbias  [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_abias  [0:AXIS_MAX-1];
    logic signed [SCALE_W-1:0]  r_gscale [0:AXIS_MAX-1];
    logic signed [SCALE_W-1:0]  r_ascale [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_gx     [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_ax     [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_res_g  [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_res_a  [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_out_g  [0:AXIS_MAX-1];
    logic signed [SW-1:0]       r_out_a  [0:AXIS_MAX-1];
    logic [1:0]                 r_axis;
    logic                       r_sens;
    logic [MCW-1:0]             r_mcnt;
    logic signed [SW-1:0]       r_rate;
    logic signed [SCALE_W-1:0]  r_sdelta;
    logic [IVL_W-1:0]           r_ivl;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SW:0]         r_inc;
    logic signed [SW:0]         r_diff;
    logic [DEN_W-1:0]           r_den;
    logic                       r_dok;
    logic                       r_fault;
    logic                       r_ofault;
    logic                       r_ovalid;

    logic                       w_in_acc;
    logic                       w_last_axis;
    logic                       w_out_load;
    logic signed [SW-1:0]       w_x;
    logic signed [SW-1:0]       w_bias;
    logic signed [SCALE_W-1:0]  w_scale;
    logic signed [SW:0]         w_diff;
    logic signed [SCALE_W+1:0]  w_divisor;
    logic signed [ACC_W-1:0]    w_pp;
    logic signed [ACC_W:0]      w_rnd;
    logic signed [SW+1:0]       w_bsum;
    logic signed [SCALE_W:0]    w_ssum;
    logic signed [SW-1:0]       w_bias_new;
    logic signed [SCALE_W-1:0]  w_scale_new;
    logic signed [SW:0]         w_neg_diff;
    logic [SW-1:0]              w_mag;
    logic signed [SW-1:0]       w_max;
    logic signed [SW-1:0]       w_min;
    logic signed [SW-1:0]       w_diff_sat;
    logic signed [SW-1:0]       w_qpos;
    logic signed [SW-1:0]       w_qres;
    logic                       w_wr;
    logic signed [SW-1:0]       w_res;
    t_div_ctl                   w_div_ctl;
    t_div_stat                  w_div_stat;
    logic [SW-2:0]              w_quo;

    assign o_in_ready = r_state == S_IDLE;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last_axis = r_axis == 2'(AXIS_COUNT - 1);
    assign w_out_load = r_state == S_OUT && (!r_ovalid || i_out_ready);

    assign w_x     = (r_sens == SENS_ACCEL) ? r_ax[r_axis]     : r_gx[r_axis];
    assign w_bias  = (r_sens == SENS_ACCEL) ? r_abias[r_axis]  : r_gbias[r_axis];
    assign w_scale = (r_sens == SENS_ACCEL) ? r_ascale[r_axis] : r_gscale[r_axis];

    assign w_diff    = {w_x[SW-1], w_x} - {w_bias[SW-1], w_bias};
    assign w_divisor = {{2{w_scale[SCALE_W-1]}}, w_scale} + DIV_ONE;

    // bias_rate * interval, interval taken MSB first
    assign w_pp  = r_ivl[IVL_W-1] ? ACC_W'(r_rate) : '0;
    assign w_rnd = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(1 << (IVL_W - 1));

    assign w_bsum = (SW + 2)'(w_bias) + (SW + 2)'(r_inc);
    assign w_ssum = (SCALE_W + 1)'(w_scale) + (SCALE_W + 1)'(r_sdelta);

    assign w_max = {1'b0, {(SW - 1){1'b1}}};
    assign w_min = {1'b1, {(SW - 1){1'b0}}};

    always_comb begin
        if (w_bsum[SW+1:SW-1] == 3'b000 || w_bsum[SW+1:SW-1] == 3'b111) begin
            w_bias_new = w_bsum[SW-1:0];
        end else begin
            w_bias_new = w_bsum[SW+1] ? w_min : w_max;
        end
        if (w_ssum[SCALE_W] == w_ssum[SCALE_W-1]) begin
            w_scale_new = w_ssum[SCALE_W-1:0];
        end else begin
            w_scale_new = w_ssum[SCALE_W] ? {1'b1, {(SCALE_W - 1){1'b0}}}
                                          : {1'b0, {(SCALE_W - 1){1'b1}}};
        end
    end

    assign w_neg_diff = -r_diff;
    assign w_mag      = r_diff[SW] ? w_neg_diff[SW-1:0] : r_diff[SW-1:0];
    assign w_diff_sat = (r_diff[SW] != r_diff[SW-1]) ? (r_diff[SW] ? w_min : w_max)
                                                      : r_diff[SW-1:0];
    assign w_qpos     = {1'b0, w_quo};

    always_comb begin
        if (w_div_stat.sat) begin
            w_qres = r_diff[SW] ? w_min : w_max;
        end else begin
            w_qres = r_diff[SW] ? -w_qpos : w_qpos;
        end
    end

    assign w_wr  = (r_state == S_LOAD && !r_dok) || (r_state == S_WAIT && w_div_stat.done);
    assign w_res = (r_state == S_LOAD) ? w_diff_sat : w_qres;

    assign w_div_ctl = '{start: r_state == S_LOAD && r_dok};

    imubsc_sdiv #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_mag   (w_mag),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fault  <= 1'b0;
            r_axis   <= '0;
            r_sens   <= SENS_GYRO;
            r_mcnt   <= '0;
            for (int i = 0; i < AXIS_MAX; i++) begin
                r_gbias[i]  <= '0;
                r_abias[i]  <= '0;
                r_gscale[i] <= '0;
                r_ascale[i] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_op == OP_SAMPLE) begin
                            r_fault <= 1'b0;
                            r_axis  <= '0;
                            r_sens  <= SENS_GYRO;
                            r_state <= S_SETUP;
                        end else if (i_axis < 2'(AXIS_COUNT)) begin
                            r_axis  <= i_axis;
                            r_sens  <= i_sensor;
                            r_mcnt  <= MCW'(IVL_W - 1);
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == '0) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_state <= S_CWB;
                end
                S_CWB: begin
                    if (r_sens == SENS_ACCEL) begin
                        r_abias[r_axis]  <= w_bias_new;
                        r_ascale[r_axis] <= w_scale_new;
                    end else begin
                        r_gbias[r_axis]  <= w_bias_new;
                        r_gscale[r_axis] <= w_scale_new;
                    end
                    r_state <= S_IDLE;
                end
                S_SETUP: begin
                    r_state <= S_LOAD;
                end
                S_LOAD, S_WAIT: begin
                    if (r_state == S_LOAD && !r_dok) begin
                        r_fault <= 1'b1;
                    end
                    if (r_state == S_LOAD && r_dok) begin
                        r_state <= S_WAIT;
                    end else if (w_wr) begin
                        if (!w_last_axis) begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_SETUP;
                        end else if (r_sens == SENS_GYRO) begin
                            r_axis  <= '0;
                            r_sens  <= SENS_ACCEL;
                            r_state <= S_SETUP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_gx[0]  <= i_gyro_x;
            r_gx[1]  <= i_gyro_y;
            r_gx[2]  <= i_gyro_z;
            r_ax[0]  <= i_accel_x;
            r_ax[1]  <= i_accel_y;
            r_ax[2]  <= i_accel_z;
            r_rate   <= i_bias_rate;
            r_sdelta <= i_scale_delta;
            r_ivl    <= i_interval;
            r_acc    <= '0;
        end
        if (r_state == S_MUL) begin
            r_acc <= (r_acc <<< 1) + w_pp;
            r_ivl <= {r_ivl[IVL_W-2:0], 1'b0};
        end
        if (r_state == S_RND) begin
            r_inc <= w_rnd[ACC_W:IVL_W];
        end
        if (r_state == S_SETUP) begin
            r_diff <= w_diff;
            r_den  <= w_divisor[DEN_W-1:0];
            r_dok  <= !w_divisor[SCALE_W+1] && (w_divisor != '0);
        end
        if (w_wr) begin
            if (r_sens == SENS_ACCEL) begin
                r_res_a[r_axis] <= w_res;
            end else begin
                r_res_g[r_axis] <= w_res;
            end
        end
        if (w_out_load) begin
            r_out_g  <= r_res_g;
            r_out_a  <= r_res_a;
            r_ofault <= r_fault;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_scale_fault  = r_ofault;
    assign o_comp_gyro_x  = r_out_g[0];
    assign o_comp_gyro_y  = (AXIS_COUNT > 1) ? r_out_g[1] : '0;
    assign o_comp_gyro_z  = (AXIS_COUNT > 2) ? r_out_g[2] : '0;
    assign o_comp_accel_x = r_out_a[0];
    assign o_comp_accel_y = (AXIS_COUNT > 1) ? r_out_a[1] : '0;
    assign o_comp_accel_z = (AXIS_COUNT > 2) ? r_out_a[2] : '0;

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_div_stat.busy)
        else $error("divider busy while block idle");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == S_WAIT)
        else $error("divider finished outside wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || i_out_ready)) |=> o_out_valid)
        else $error("result not presented after load");

    a_fault_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == OP_SAMPLE) |=> !r_fault)
        else $error("fault flag not cleared at sample start");

endmodule
